@@ src/lss_pkg.sv @@
// lss_pkg: shared constants, mode codes, register indexes and payload types
// for the light seeking swivel controller; no dependencies
`timescale 1ns / 1ps

package lss_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 8;

    localparam int GAIN_W     = 9;
    localparam int GAIN_SHIFT = 8;
    localparam logic [GAIN_W-1:0] GAIN_FULL = 9'd256;

    localparam int TICKS_W = 8;
    localparam int STEPS_W = 8;
    localparam int COUNT_W = 9;
    localparam int MODE_W  = 3;
    localparam int STEP_W  = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [MODE_W-1:0] MODE_CALIBRATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VERIFY    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TURN      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF       = 3'd4;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_FILTER_GAIN    = 2'd0;
    localparam logic [1:0] REG_CONFIRM_TICKS  = 2'd1;
    localparam logic [1:0] REG_STEPS_PER_MOVE = 2'd2;

    localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST    = 9'd77;
    localparam logic [TICKS_W-1:0] CONFIRM_TICKS_RST  = 8'd66;
    localparam logic [STEPS_W-1:0] STEPS_PER_MOVE_RST = 8'd10;

    typedef logic [SAMPLE_BITS:0] lvl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] front_raw;
        logic [SAMPLE_BITS-1:0] back_raw;
        logic [SAMPLE_BITS-1:0] left_raw;
        logic [SAMPLE_BITS-1:0] right_raw;
        logic                   swivel_enable;
    } in_t;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_command;
        logic [MODE_W-1:0]        tracker_mode;
        logic                     indicator_on;
    } out_t;

endpackage

@@ src/lss_filter.sv @@
// lss_filter: one inverted-sample exponential smoothing channel with its level register
// depends on lss_pkg
`timescale 1ns / 1ps

module lss_filter #(
    parameter int FRAC_BITS = lss_pkg::FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               update,
    input  logic [lss_pkg::GAIN_W-1:0]         gain,
    input  logic [lss_pkg::SAMPLE_BITS-1:0]    raw,
    output lss_pkg::lvl_t                      level_int
);

    localparam int VAL_W   = lss_pkg::SAMPLE_BITS + 1;
    localparam int LEVEL_W = VAL_W + FRAC_BITS;
    localparam int SUM_W   = LEVEL_W + lss_pkg::GAIN_W;

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [VAL_W-1:0]   inv_val;
    logic [lss_pkg::GAIN_W-1:0] gain_c;
    logic [SUM_W-1:0]   prod_in;
    logic [SUM_W-1:0]   prod_lvl;
    logic [SUM_W-1:0]   sum;

    always_comb begin
        inv_val    = (VAL_W'(1) << lss_pkg::SAMPLE_BITS) - {1'b0, raw};
        gain_c     = lss_pkg::GAIN_FULL - gain;
        prod_in    = SUM_W'(gain) * SUM_W'({inv_val, {FRAC_BITS{1'b0}}});
        prod_lvl   = SUM_W'(gain_c) * SUM_W'(level_reg);
        sum        = prod_in + prod_lvl;
        level_next = sum[LEVEL_W+lss_pkg::GAIN_SHIFT-1:lss_pkg::GAIN_SHIFT];
    end

    assign level_int = level_next[LEVEL_W-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (update) begin
            level_reg <= level_next;
        end
    end

endmodule

@@ src/lss_tracker.sv @@
// lss_tracker: mode machine with verify counter and step command generation
// depends on lss_pkg
`timescale 1ns / 1ps

module lss_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic                          enable,
    input  lss_pkg::lvl_t                 lv_front,
    input  lss_pkg::lvl_t                 lv_back,
    input  lss_pkg::lvl_t                 lv_left,
    input  lss_pkg::lvl_t                 lv_right,
    input  logic [lss_pkg::TICKS_W-1:0]   confirm_ticks,
    input  logic [lss_pkg::STEPS_W-1:0]   steps_per_move,
    output lss_pkg::out_t                 result
);

    logic [lss_pkg::MODE_W-1:0]  mode_reg;
    logic [lss_pkg::MODE_W-1:0]  mode_next;
    logic [lss_pkg::MODE_W-1:0]  mode_cur;
    logic [lss_pkg::COUNT_W-1:0] count_reg;
    logic [lss_pkg::COUNT_W-1:0] count_next;
    logic [lss_pkg::COUNT_W-1:0] count_upd;
    logic signed [lss_pkg::STEP_W-1:0] step;
    logic not_best;
    logic best;

    assign not_best = (lv_front < lv_right) || (lv_front < lv_back) || (lv_front < lv_left);
    assign best     = (lv_front > lv_right) && (lv_front > lv_back) && (lv_front > lv_left);

    always_comb begin
        mode_cur   = enable ? mode_reg : lss_pkg::MODE_OFF;
        mode_next  = mode_cur;
        count_next = count_reg;
        count_upd  = count_reg;
        step       = '0;
        case (mode_cur)
            lss_pkg::MODE_IDLE: begin
                if (not_best) begin
                    mode_next  = lss_pkg::MODE_VERIFY;
                    count_next = '0;
                end
            end
            lss_pkg::MODE_VERIFY: begin
                if (not_best) begin
                    if (count_reg < lss_pkg::COUNT_MAX) begin
                        count_upd = count_reg + 1'b1;
                    end
                end else if (count_reg != '0) begin
                    count_upd = count_reg - 1'b1;
                end
                count_next = count_upd;
                if (count_upd > lss_pkg::COUNT_W'(confirm_ticks)) begin
                    mode_next = lss_pkg::MODE_TURN;
                end else if (count_upd == '0) begin
                    mode_next = lss_pkg::MODE_IDLE;
                end
            end
            lss_pkg::MODE_TURN: begin
                if (best) begin
                    mode_next = lss_pkg::MODE_IDLE;
                end else if (lv_right > lv_left) begin
                    step = -$signed({1'b0, steps_per_move});
                end else begin
                    step = $signed({1'b0, steps_per_move});
                end
            end
            lss_pkg::MODE_OFF: begin
                if (enable) begin
                    mode_next = lss_pkg::MODE_CALIBRATE;
                end
            end
            default: begin
                mode_next = lss_pkg::MODE_IDLE;
            end
        endcase
    end

    assign result.step_command = step;
    assign result.tracker_mode = mode_next;
    assign result.indicator_on = enable;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lss_pkg::MODE_CALIBRATE;
            count_reg <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    a_disable_forces_off: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !enable |=> mode_reg == lss_pkg::MODE_OFF)
        else $error("disabled transaction did not leave mode off");

    a_step_only_turning: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && mode_reg != lss_pkg::MODE_TURN |-> step == '0)
        else $error("step commanded outside turn mode");

    a_off_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && enable && mode_reg == lss_pkg::MODE_OFF |=> mode_reg == lss_pkg::MODE_CALIBRATE)
        else $error("off mode did not restart calibration");

    a_calibrate_once: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && enable && mode_reg == lss_pkg::MODE_CALIBRATE |=> mode_reg == lss_pkg::MODE_IDLE)
        else $error("calibrate lasted more than one transaction");

endmodule

@@ src/light_seeking_swivel_controller.sv @@
// light_seeking_swivel_controller: top level with config registers, input and result registers
// depends on lss_pkg, lss_filter, lss_tracker
//
// usage:
//   s_ channel carries one tick of four raw light samples and the enable switch
//   m_ channel returns one result per tick: step command, mode, indicator
//   config registers sit on the apb port: 0x0 filter_gain, 0x4 confirm_ticks,
//   0x8 steps_per_move; pready is always high, reads return the register value
//   a transaction accepted into the input register moves on to the result register
//   once that is free, and shows on the m_ channel from then on
//   throughput: one transaction per cycle while results are taken; filter multiplies, compares and the
//   mode machine all sit between the input register and the result register
//   a stalled receiver holds the result; the input register takes one more
//   transaction only if it is empty, then s_ready drops until the result is taken
//   reset clears the filter levels, verify count and both valid flags, sets the
//   mode to calibrate and loads the register reset values
`timescale 1ns / 1ps

module light_seeking_swivel_controller #(
    parameter int FRAC_BITS = lss_pkg::FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lss_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lss_pkg::out_t                 m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lss_pkg::ADDR_W-1:0]    paddr,
    input  logic [lss_pkg::DATA_W-1:0]    pwdata,
    output logic [lss_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [lss_pkg::GAIN_W-1:0]  filter_gain_reg;
    logic [lss_pkg::TICKS_W-1:0] confirm_ticks_reg;
    logic [lss_pkg::STEPS_W-1:0] steps_per_move_reg;
    logic [lss_pkg::GAIN_W-1:0]  gain_eff;

    lss_pkg::in_t  in_reg;
    logic          in_valid_reg;
    lss_pkg::out_t out_reg;
    logic          out_valid_reg;
    lss_pkg::out_t result;
    logic          out_free;
    logic          advance;
    logic          cfg_write;

    lss_pkg::lvl_t lv_front;
    lss_pkg::lvl_t lv_back;
    lss_pkg::lvl_t lv_left;
    lss_pkg::lvl_t lv_right;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_gain_reg    <= lss_pkg::FILTER_GAIN_RST;
            confirm_ticks_reg  <= lss_pkg::CONFIRM_TICKS_RST;
            steps_per_move_reg <= lss_pkg::STEPS_PER_MOVE_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                lss_pkg::REG_FILTER_GAIN:    filter_gain_reg    <= pwdata[lss_pkg::GAIN_W-1:0];
                lss_pkg::REG_CONFIRM_TICKS:  confirm_ticks_reg  <= pwdata[lss_pkg::TICKS_W-1:0];
                lss_pkg::REG_STEPS_PER_MOVE: steps_per_move_reg <= pwdata[lss_pkg::STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lss_pkg::REG_FILTER_GAIN:    prdata = lss_pkg::DATA_W'(filter_gain_reg);
            lss_pkg::REG_CONFIRM_TICKS:  prdata = lss_pkg::DATA_W'(confirm_ticks_reg);
            lss_pkg::REG_STEPS_PER_MOVE: prdata = lss_pkg::DATA_W'(steps_per_move_reg);
            default:                     prdata = '0;
        endcase
    end

    assign gain_eff = (filter_gain_reg > lss_pkg::GAIN_FULL) ? lss_pkg::GAIN_FULL
                                                              : filter_gain_reg;

    // handshake and pipeline control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    lss_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_front (
        .aclk(aclk), .aresetn(aresetn), .update(advance), .gain(gain_eff),
        .raw(in_reg.front_raw), .level_int(lv_front)
    );

    lss_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_back (
        .aclk(aclk), .aresetn(aresetn), .update(advance), .gain(gain_eff),
        .raw(in_reg.back_raw), .level_int(lv_back)
    );

    lss_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_left (
        .aclk(aclk), .aresetn(aresetn), .update(advance), .gain(gain_eff),
        .raw(in_reg.left_raw), .level_int(lv_left)
    );

    lss_filter #(.FRAC_BITS(FRAC_BITS)) u_filt_right (
        .aclk(aclk), .aresetn(aresetn), .update(advance), .gain(gain_eff),
        .raw(in_reg.right_raw), .level_int(lv_right)
    );

    lss_tracker u_tracker (
        .aclk(aclk),
        .aresetn(aresetn),
        .fire(advance),
        .enable(in_reg.swivel_enable),
        .lv_front(lv_front),
        .lv_back(lv_back),
        .lv_left(lv_left),
        .lv_right(lv_right),
        .confirm_ticks(confirm_ticks_reg),
        .steps_per_move(steps_per_move_reg),
        .result(result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
